FILE: design/fixed_block_pool_allocator_defines.svh
// Assertion macros for the fixed block pool allocator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define FBPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fbpa_pkg.sv
// Shared codes and widths for the fixed block pool allocator.
// No dependencies.
`default_nettype none

package fbpa_pkg;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int SIZE_W   = 16;
    localparam int IDX_W    = 8;
    localparam int STAT_W   = 2;
    localparam int BYTES_W  = 24;
    localparam int CNT32_W  = 32;
    localparam int BCOUNT_W = 9;

    // Configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
    localparam logic [1:0] REG_BLOCK_COUNT = 2'd1;
    localparam logic [1:0] REG_HEAP_BYTES  = 2'd2;

    localparam logic [SIZE_W-1:0]   BLOCK_SIZE_RST = 16'd64;
    localparam logic [BYTES_W-1:0]  BYTES_MAX      = 24'hFF_FFFF;
    localparam logic [CNT32_W-1:0]  FAIL_MAX       = 32'hFFFF_FFFF;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;

    // Response status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_ALLOC_ERR = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREE_DROP = 2'd2;

endpackage

`default_nettype wire

FILE: design/fbpa_req_if.sv
// Request channel of the fixed block pool allocator.
// Depends on fbpa_pkg.
`default_nettype none

interface fbpa_req_if;
    logic                          valid;
    logic                          ready;
    logic [fbpa_pkg::KIND_W-1:0]   kind;
    logic [fbpa_pkg::SIZE_W-1:0]   request_size;
    logic [fbpa_pkg::IDX_W-1:0]    block_index;

    modport source (output valid, kind, request_size, block_index, input ready);
    modport sink   (input valid, kind, request_size, block_index, output ready);
endinterface

`default_nettype wire

FILE: design/fbpa_rsp_if.sv
// Response channel of the fixed block pool allocator.
// Depends on fbpa_pkg.
`default_nettype none

interface fbpa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [fbpa_pkg::STAT_W-1:0]    status;
    logic [fbpa_pkg::IDX_W-1:0]     granted_index;
    logic [fbpa_pkg::BYTES_W-1:0]   free_bytes;
    logic [fbpa_pkg::BYTES_W-1:0]   peak_used_bytes;
    logic [fbpa_pkg::CNT32_W-1:0]   failed_requests;

    modport source (output valid, status, granted_index, free_bytes, peak_used_bytes,
                    failed_requests, input ready);
    modport sink   (input valid, status, granted_index, free_bytes, peak_used_bytes,
                    failed_requests, output ready);
endinterface

`default_nettype wire

FILE: design/fbpa_ring.sv
// Free-list ring storage: one write port, one read port, registered read data.
// Depends on fbpa_pkg.
`default_nettype none

module fbpa_ring #(
    parameter int DEPTH = 256
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [$clog2(DEPTH)-1:0]    waddr,
    input  wire logic [fbpa_pkg::IDX_W-1:0]  wdata,
    input  wire logic [$clog2(DEPTH)-1:0]    raddr,
    output      logic [fbpa_pkg::IDX_W-1:0]  rdata
);

    logic [fbpa_pkg::IDX_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/fixed_block_pool_allocator.sv
// Fixed block pool allocator top level: sequencer, statistics, APB registers.
// Depends on fbpa_pkg, fbpa_req_if, fbpa_rsp_if, fbpa_ring and the defines header.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  req     | in  | valid/ready          | kind, request_size, block_index
//  rsp     | out | valid/ready          | status, granted_index, free_bytes,
//          |     |                      | peak_used_bytes, failed_requests
//  apb     | in  | psel/penable, pready | paddr, pwdata, pwrite -> prdata
//
// A request walks accept, align, execute, product and statistics steps through
// the ring memory and three multipliers, one request at a time.
// An init request also places min(block_count, MAX_BLOCKS) blocks in its init step.
// Reset clears the control state; the ring holds no valid data until written.
// A new request is taken while a response waits; a stalled rsp holds the
// sequencer in its last step until the response register frees.
`default_nettype none

`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS  = 256,
    parameter int ALIGN_BYTES = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    fbpa_req_if.sink                            req,
    fbpa_rsp_if.source                          rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fbpa_pkg::APB_AW-1:0]    paddr,
    input  wire logic [fbpa_pkg::APB_DW-1:0]    pwdata,
    output      logic [fbpa_pkg::APB_DW-1:0]    prdata,
    output      logic                           pready
);

    localparam int PTR_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int NCMP_W = (CNT_W > fbpa_pkg::BCOUNT_W) ? CNT_W : fbpa_pkg::BCOUNT_W;

    // Align by reciprocal multiply: floor(x / ALIGN) exact for x < 2**X_W
    localparam int X_W     = fbpa_pkg::SIZE_W + 1;
    localparam int SHIFT   = X_W + $clog2(ALIGN_BYTES);
    localparam int RECIP_W = X_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
    localparam int APROD_W = X_W + RECIP_W;

    localparam int FPROD_W = CNT_W + fbpa_pkg::SIZE_W;
    localparam int STW     = (FPROD_W > fbpa_pkg::BYTES_W) ? FPROD_W : fbpa_pkg::BYTES_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_INIT = 3'd3;
    localparam logic [2:0] S_PROD = 3'd4;
    localparam logic [2:0] S_STAT = 3'd5;

    // ---------------- configuration registers ----------------
    logic [fbpa_pkg::SIZE_W-1:0]   bsize_reg;
    logic [fbpa_pkg::BCOUNT_W-1:0] bcount_reg;
    logic [fbpa_pkg::BYTES_W-1:0]  heap_reg;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsize_reg  <= fbpa_pkg::BLOCK_SIZE_RST;
            bcount_reg <= '0;
            heap_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                fbpa_pkg::REG_BLOCK_SIZE:  bsize_reg  <= pwdata[fbpa_pkg::SIZE_W-1:0];
                fbpa_pkg::REG_BLOCK_COUNT: bcount_reg <= pwdata[fbpa_pkg::BCOUNT_W-1:0];
                fbpa_pkg::REG_HEAP_BYTES:  heap_reg   <= pwdata[fbpa_pkg::BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            fbpa_pkg::REG_BLOCK_SIZE:  prdata = fbpa_pkg::APB_DW'(bsize_reg);
            fbpa_pkg::REG_BLOCK_COUNT: prdata = fbpa_pkg::APB_DW'(bcount_reg);
            fbpa_pkg::REG_HEAP_BYTES:  prdata = fbpa_pkg::APB_DW'(heap_reg);
            default:                   prdata = '0;
        endcase
    end

    // ---------------- control state ----------------
    logic [2:0]                    state_reg, state_next;
    logic [PTR_W-1:0]              head_reg, head_next;
    logic [PTR_W-1:0]              tail_reg, tail_next;
    logic [CNT_W-1:0]              total_reg, total_next;
    logic [fbpa_pkg::BYTES_W-1:0]  peak_reg, peak_next;
    logic [fbpa_pkg::CNT32_W-1:0]  fail_reg, fail_next;
    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic                          rsp_valid_reg, rsp_valid_next;

    // ---------------- payload registers ----------------
    logic [fbpa_pkg::KIND_W-1:0]   kind_reg;
    logic [fbpa_pkg::IDX_W-1:0]    idx_reg;
    logic [APROD_W-1:0]            aprod_reg;
    logic [X_W-1:0]                rnd_reg;
    logic [FPROD_W-1:0]            fprod_reg;
    logic [fbpa_pkg::STAT_W-1:0]   status_reg, status_next;
    logic [fbpa_pkg::IDX_W-1:0]    grant_reg, grant_next;
    logic                          succ_reg, succ_next;
    logic [fbpa_pkg::STAT_W-1:0]   o_status_reg;
    logic [fbpa_pkg::IDX_W-1:0]    o_grant_reg;
    logic [fbpa_pkg::BYTES_W-1:0]  o_free_reg;
    logic [fbpa_pkg::BYTES_W-1:0]  o_peak_reg;
    logic [fbpa_pkg::CNT32_W-1:0]  o_fail_reg;

    // ring memory port
    logic                          ring_we;
    logic [PTR_W-1:0]              ring_waddr;
    logic [fbpa_pkg::IDX_W-1:0]    ring_wdata;
    logic [fbpa_pkg::IDX_W-1:0]    ring_rdata;

    fbpa_ring #(
        .DEPTH (MAX_BLOCKS)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    logic                         req_fire;
    logic                         slot_free;
    logic [X_W-1:0]               quot;
    logic                         fits;
    logic [CNT_W-1:0]             n_init;
    logic [STW-1:0]               f_ext;
    logic [STW-1:0]               h_ext;
    logic [fbpa_pkg::BYTES_W-1:0] free_sat;
    logic [fbpa_pkg::BYTES_W-1:0] used;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign slot_free = !rsp_valid_reg || rsp.ready;

    assign quot = X_W'(aprod_reg >> SHIFT);
    assign fits = (rnd_reg <= X_W'(bsize_reg)) && (total_reg != '0);

    // blocks placed by init, clamped to the ring depth
    assign n_init = (NCMP_W'(bcount_reg) > NCMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                                 : CNT_W'(bcount_reg);

    // free bytes and used bytes, both saturating
    assign f_ext    = STW'(fprod_reg);
    assign h_ext    = STW'(heap_reg);
    assign free_sat = (f_ext > STW'(fbpa_pkg::BYTES_MAX)) ? fbpa_pkg::BYTES_MAX
                                                          : f_ext[fbpa_pkg::BYTES_W-1:0];
    assign used     = (f_ext >= h_ext) ? '0 : fbpa_pkg::BYTES_W'(h_ext - f_ext);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        total_next     = total_reg;
        peak_next      = peak_reg;
        fail_next      = fail_reg;
        fill_next      = fill_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        grant_next     = grant_reg;
        succ_next      = succ_reg;
        ring_we        = 1'b0;
        ring_waddr     = tail_reg;
        ring_wdata     = idx_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                status_next = fbpa_pkg::ST_OK;
                grant_next  = '0;
                succ_next   = 1'b0;
                state_next  = S_PROD;
                case (kind_reg)
                    fbpa_pkg::KIND_ALLOC:
                    begin
                        if (fits)
                        begin
                            grant_next = ring_rdata;
                            succ_next  = 1'b1;
                            head_next  = (head_reg == PTR_W'(MAX_BLOCKS - 1)) ? '0
                                                                             : head_reg + 1'b1;
                            total_next = total_reg - 1'b1;
                        end
                        else
                        begin
                            status_next = fbpa_pkg::ST_ALLOC_ERR;
                            if (fail_reg != fbpa_pkg::FAIL_MAX)
                            begin
                                fail_next = fail_reg + 1'b1;
                            end
                        end
                    end
                    fbpa_pkg::KIND_FREE:
                    begin
                        if (total_reg >= CNT_W'(MAX_BLOCKS))
                        begin
                            status_next = fbpa_pkg::ST_FREE_DROP;
                        end
                        else
                        begin
                            ring_we    = 1'b1;
                            tail_next  = (tail_reg == PTR_W'(MAX_BLOCKS - 1)) ? '0
                                                                             : tail_reg + 1'b1;
                            total_next = total_reg + 1'b1;
                        end
                    end
                    fbpa_pkg::KIND_INIT:
                    begin
                        head_next  = '0;
                        tail_next  = (n_init == CNT_W'(MAX_BLOCKS)) ? '0
                                                                    : PTR_W'(n_init);
                        total_next = n_init;
                        peak_next  = '0;
                        fail_next  = '0;
                        fill_next  = '0;
                        if (n_init != '0)
                        begin
                            state_next = S_INIT;
                        end
                    end
                    default: ;
                endcase
            end
            S_INIT:
            begin
                // place index i at ring entry i
                ring_we    = 1'b1;
                ring_waddr = fill_reg[PTR_W-1:0];
                ring_wdata = fbpa_pkg::IDX_W'(fill_reg);
                fill_next  = fill_reg + 1'b1;
                if (fill_reg + 1'b1 == total_reg)
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                state_next = S_STAT;
            end
            S_STAT:
            begin
                if (slot_free)
                begin
                    if (succ_reg && (used > peak_reg))
                    begin
                        peak_next = used;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            total_reg     <= '0;
            peak_reg      <= '0;
            fail_reg      <= '0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            total_reg     <= total_next;
            peak_reg      <= peak_next;
            fail_reg      <= fail_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        grant_reg  <= grant_next;
        succ_reg   <= succ_next;
        if (req_fire)
        begin
            kind_reg  <= req.kind;
            idx_reg   <= req.block_index;
            aprod_reg <= APROD_W'((X_W'(req.request_size) + X_W'(ALIGN_BYTES - 1)) * RECIP);
        end
        if (state_reg == S_EVAL)
        begin
            rnd_reg <= X_W'(quot * X_W'(ALIGN_BYTES));
        end
        if (state_reg == S_PROD)
        begin
            fprod_reg <= FPROD_W'(total_reg * bsize_reg);
        end
        // statistics are frozen with the response so a following request cannot alter them
        if ((state_reg == S_STAT) && slot_free)
        begin
            o_status_reg <= status_reg;
            o_grant_reg  <= grant_reg;
            o_free_reg   <= free_sat;
            o_peak_reg   <= peak_next;
            o_fail_reg   <= fail_reg;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = o_status_reg;
    assign rsp.granted_index   = o_grant_reg;
    assign rsp.free_bytes      = o_free_reg;
    assign rsp.peak_used_bytes = o_peak_reg;
    assign rsp.failed_requests = o_fail_reg;

    // ---------------- assertions ----------------
    `FBPA_ASSERT_NOW(a_total_bound, 1'b1, total_reg <= CNT_W'(MAX_BLOCKS), "free count past depth")
    `FBPA_ASSERT_NOW(a_grant_on_ok, rsp.valid && (rsp.status != fbpa_pkg::ST_OK),
                     rsp.granted_index == '0, "index granted on a failed request")
    `FBPA_ASSERT_NEXT(a_fail_mono, !((state_reg == S_EXEC) && (kind_reg == fbpa_pkg::KIND_INIT)),
                      fail_reg >= $past(fail_reg), "failure counter went down without init")
    `FBPA_ASSERT_NEXT(a_accept_busy, req_fire, state_reg == S_EVAL, "accepted request not started")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the fixed block pool allocator: directed table plus random
// alloc/free/init traffic, checked against a local model of the free-index ring.
// Depends on fbpa_pkg, fbpa_req_if, fbpa_rsp_if and the fixed_block_pool_allocator RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int          CLK_PERIOD     = 10;
    localparam int unsigned POOL_DEPTH     = 256;
    localparam int unsigned POOL_ALIGN     = 8;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          REPORT_LIMIT   = 10;
    localparam int unsigned PHASE_ITEMS    = 134;
    localparam int          HOLD_OFF       = 300;
    localparam int          END_PAUSE      = 20;

    // kind 3 is not a defined request; the block must ignore it
    localparam logic [fbpa_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic [fbpa_pkg::STAT_W-1:0]  status;
        logic [fbpa_pkg::IDX_W-1:0]   granted_index;
        logic [fbpa_pkg::BYTES_W-1:0] free_bytes;
        logic [fbpa_pkg::BYTES_W-1:0] peak_used_bytes;
        logic [fbpa_pkg::CNT32_W-1:0] failed_requests;
    } pool_reply_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_TYPED, ROW_PRED} row_op_t;

    // For ROW_CFG rows size/count/heap are the register values
    typedef struct packed {
        row_op_t                       op;
        logic [fbpa_pkg::KIND_W-1:0]   kind;
        logic [fbpa_pkg::SIZE_W-1:0]   size;
        logic [fbpa_pkg::IDX_W-1:0]    idx;
        logic [fbpa_pkg::BCOUNT_W-1:0] count;
        logic [fbpa_pkg::BYTES_W-1:0]  heap;
        pool_reply_t                   want;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [26] = '{
        // after reset: empty pool, block_size 64
        '{ROW_TYPED, fbpa_pkg::KIND_ALLOC, 0,     0,     0,   0,
          '{fbpa_pkg::ST_ALLOC_ERR, 0, 0, 0, 1}},
        '{ROW_TYPED, KIND_NONE,            65535, 255,   0,   0,
          '{fbpa_pkg::ST_OK, 0, 0, 0, 1}},
        '{ROW_TYPED, fbpa_pkg::KIND_FREE,  0,     255,   0,   0,
          '{fbpa_pkg::ST_OK, 0, 64, 0, 1}},
        '{ROW_TYPED, fbpa_pkg::KIND_ALLOC, 64,    0,     0,   0,
          '{fbpa_pkg::ST_OK, 255, 0, 0, 1}},
        '{ROW_TYPED, fbpa_pkg::KIND_ALLOC, 65535, 0,     0,   0,
          '{fbpa_pkg::ST_ALLOC_ERR, 0, 0, 0, 2}},
        // largest pool: full ring, rounding past the block size
        '{ROW_CFG,   KIND_NONE,            65535, 0,     256, fbpa_pkg::BYTES_MAX, '0},
        '{ROW_TYPED, fbpa_pkg::KIND_INIT,  0,     0,     0,   0,
          '{fbpa_pkg::ST_OK, 0, 16776960, 0, 0}},
        '{ROW_TYPED, fbpa_pkg::KIND_FREE,  0,     0,     0,   0,
          '{fbpa_pkg::ST_FREE_DROP, 0, 16776960, 0, 0}},
        '{ROW_TYPED, fbpa_pkg::KIND_ALLOC, 65535, 0,     0,   0,
          '{fbpa_pkg::ST_ALLOC_ERR, 0, 16776960, 0, 1}},
        '{ROW_PRED,  fbpa_pkg::KIND_ALLOC, 65528, 0,     0,   0,         '0},
        '{ROW_PRED,  fbpa_pkg::KIND_ALLOC, 1,     0,     0,   0,         '0},
        '{ROW_PRED,  fbpa_pkg::KIND_FREE,  0,     8'hAA, 0,   0,         '0},
        // zero block size, count above the ring depth
        '{ROW_CFG,   KIND_NONE,            0,     0,     511, 100,       '0},
        '{ROW_TYPED, fbpa_pkg::KIND_INIT,  0,     0,     0,   0,
          '{fbpa_pkg::ST_OK, 0, 0, 0, 0}},
        '{ROW_TYPED, fbpa_pkg::KIND_ALLOC, 0,     0,     0,   0,
          '{fbpa_pkg::ST_OK, 0, 0, 100, 0}},
        '{ROW_TYPED, fbpa_pkg::KIND_ALLOC, 1,     0,     0,   0,
          '{fbpa_pkg::ST_ALLOC_ERR, 0, 0, 100, 1}},
        // heap smaller than free bytes: used figure clamps at zero
        '{ROW_CFG,   KIND_NONE,            1000,  0,     10,  500,       '0},
        '{ROW_TYPED, fbpa_pkg::KIND_INIT,  0,     0,     0,   0,
          '{fbpa_pkg::ST_OK, 0, 10000, 0, 0}},
        '{ROW_TYPED, fbpa_pkg::KIND_ALLOC, 999,   0,     0,   0,
          '{fbpa_pkg::ST_OK, 0, 9000, 0, 0}},
        '{ROW_PRED,  fbpa_pkg::KIND_ALLOC, 1001,  0,     0,   0,         '0},
        // empty init, then a double free of the same index
        '{ROW_CFG,   KIND_NONE,            8,     0,     0,   0,         '0},
        '{ROW_TYPED, fbpa_pkg::KIND_INIT,  0,     0,     0,   0,
          '{fbpa_pkg::ST_OK, 0, 0, 0, 0}},
        '{ROW_TYPED, fbpa_pkg::KIND_ALLOC, 8,     0,     0,   0,
          '{fbpa_pkg::ST_ALLOC_ERR, 0, 0, 0, 1}},
        '{ROW_PRED,  fbpa_pkg::KIND_FREE,  0,     8'h5A, 0,   0,         '0},
        '{ROW_PRED,  fbpa_pkg::KIND_FREE,  0,     8'h5A, 0,   0,         '0},
        '{ROW_PRED,  fbpa_pkg::KIND_ALLOC, 7,     0,     0,   0,         '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [fbpa_pkg::APB_AW-1:0] paddr;
    logic [fbpa_pkg::APB_DW-1:0] pwdata;
    logic [fbpa_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    fbpa_req_if req_ch ();
    fbpa_rsp_if rsp_ch ();

    fixed_block_pool_allocator #(
        .MAX_BLOCKS  (POOL_DEPTH),
        .ALIGN_BYTES (POOL_ALIGN)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Model state: free-index ring, statistics and register shadows
    logic [fbpa_pkg::IDX_W-1:0]    pool_ring [POOL_DEPTH];
    int unsigned                   ring_head;
    int unsigned                   ring_tail;
    int unsigned                   free_total;
    logic [fbpa_pkg::BYTES_W-1:0]  peak_used;
    logic [fbpa_pkg::CNT32_W-1:0]  fail_count;
    logic [fbpa_pkg::SIZE_W-1:0]   cfg_block_size;
    logic [fbpa_pkg::BCOUNT_W-1:0] cfg_block_count;
    logic [fbpa_pkg::BYTES_W-1:0]  cfg_heap_bytes;

    pool_reply_t                pool_replies_due [$];
    logic [fbpa_pkg::IDX_W-1:0] held_blocks [$];

    // Driver to monitor: typed-in expectation for the request on the bus
    bit          want_typed;
    pool_reply_t typed_reply;

    int src_idle_pct;
    int snk_idle_pct;
    int rsp_hold;
    int reply_errors;
    int requests_seen;
    int replies_checked;
    int grants;
    int refusals;
    int dropped_frees;
    int inits;
    int settings;
    int quiet_cycles;

    // Next reply of the pool for one request; updates the model state
    function automatic pool_reply_t predict_pool(input logic [fbpa_pkg::KIND_W-1:0] kind,
                                                 input logic [fbpa_pkg::SIZE_W-1:0] size,
                                                 input logic [fbpa_pkg::IDX_W-1:0]  idx);
        pool_reply_t                  res;
        int unsigned                  rounded;
        int unsigned                  n;
        longint unsigned              product;
        logic [fbpa_pkg::BYTES_W-1:0] used;
        res = '0;
        res.status = fbpa_pkg::ST_OK;
        case (kind)
            fbpa_pkg::KIND_ALLOC:
            begin
                // rounded size kept at full width, never wraps
                rounded = (32'(size) + POOL_ALIGN - 1) / POOL_ALIGN * POOL_ALIGN;
                if (rounded <= 32'(cfg_block_size) && free_total > 0)
                begin
                    res.granted_index = pool_ring[ring_head];
                    ring_head = (ring_head + 1) % POOL_DEPTH;
                    free_total--;
                    product = 64'(free_total) * 64'(cfg_block_size);
                    if (product >= 64'(cfg_heap_bytes))
                        used = '0;
                    else
                        used = 24'(64'(cfg_heap_bytes) - product);
                    if (used > peak_used)
                        peak_used = used;
                end
                else
                begin
                    res.status = fbpa_pkg::ST_ALLOC_ERR;
                    if (fail_count != fbpa_pkg::FAIL_MAX)
                        fail_count++;
                end
            end
            fbpa_pkg::KIND_FREE:
            begin
                if (free_total >= POOL_DEPTH)
                    res.status = fbpa_pkg::ST_FREE_DROP;
                else
                begin
                    pool_ring[ring_tail] = idx;
                    ring_tail = (ring_tail + 1) % POOL_DEPTH;
                    free_total++;
                end
            end
            fbpa_pkg::KIND_INIT:
            begin
                n = (32'(cfg_block_count) > POOL_DEPTH) ? POOL_DEPTH : 32'(cfg_block_count);
                for (int i = 0; i < int'(n); i++)
                    pool_ring[i] = 8'(i);
                ring_head  = 0;
                ring_tail  = (n >= POOL_DEPTH) ? 0 : n;
                free_total = n;
                peak_used  = '0;
                fail_count = '0;
            end
            default: ;
        endcase
        product = 64'(free_total) * 64'(cfg_block_size);
        res.free_bytes      = (product > 64'(fbpa_pkg::BYTES_MAX)) ? fbpa_pkg::BYTES_MAX
                                                                  : product[fbpa_pkg::BYTES_W-1:0];
        res.peak_used_bytes = peak_used;
        res.failed_requests = fail_count;
        return res;
    endfunction

    task automatic note_error(input string msg);
        if (reply_errors < REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        reply_errors++;
    endtask

    task automatic check_field(input string what, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
            note_error($sformatf("%s expected %0d got %0d", what, want, got));
    endtask

    // One APB transfer, entered and left at a falling edge
    task automatic apb_transfer(input bit write, input logic [fbpa_pkg::APB_AW-1:0] addr,
                                input logic [fbpa_pkg::APB_DW-1:0] wdata,
                                output logic [fbpa_pkg::APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Write all three registers, read each one back, update the shadows
    task automatic program_pool(input logic [fbpa_pkg::SIZE_W-1:0] block_size,
                                input logic [fbpa_pkg::BCOUNT_W-1:0] block_count,
                                input logic [fbpa_pkg::BYTES_W-1:0] heap_bytes);
        logic [1:0]                  regs [3];
        logic [fbpa_pkg::APB_DW-1:0] vals [3];
        logic [fbpa_pkg::APB_DW-1:0] rd;
        regs[0] = fbpa_pkg::REG_BLOCK_SIZE;
        regs[1] = fbpa_pkg::REG_BLOCK_COUNT;
        regs[2] = fbpa_pkg::REG_HEAP_BYTES;
        vals[0] = 32'(block_size);
        vals[1] = 32'(block_count);
        vals[2] = 32'(heap_bytes);
        for (int r = 0; r < 3; r++)
        begin
            apb_transfer(1'b1, {regs[r], 2'b00}, vals[r], rd);
            cfg_block_size  = (r == 0) ? block_size  : cfg_block_size;
            cfg_block_count = (r == 1) ? block_count : cfg_block_count;
            cfg_heap_bytes  = (r == 2) ? heap_bytes  : cfg_heap_bytes;
            apb_transfer(1'b0, {regs[r], 2'b00}, '0, rd);
            check_field($sformatf("register %0d readback", r), vals[r], rd);
        end
        settings++;
    endtask

    // Stop offering requests and wait until every reply is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pool_replies_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Offer one request; returns at the falling edge after it was taken
    task automatic send_request(input logic [fbpa_pkg::KIND_W-1:0] kind,
                                input logic [fbpa_pkg::SIZE_W-1:0] size,
                                input logic [fbpa_pkg::IDX_W-1:0] idx, input bit typed,
                                input pool_reply_t want);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        want_typed  = typed;
        typed_reply = want;
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= kind;
        req_ch.request_size <= size;
        req_ch.block_index  <= idx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random pool setting (extremes weighted in), then rebuild the pool
    task automatic reshape_pool();
        logic [fbpa_pkg::SIZE_W-1:0]   bs;
        logic [fbpa_pkg::BCOUNT_W-1:0] cnt;
        logic [fbpa_pkg::BYTES_W-1:0]  heap;
        int unsigned                   r;
        case ($urandom_range(0, 7))
            0: bs = 16'd0;
            1: bs = 16'd1;
            2: bs = 16'd8;
            3: bs = 16'd64;
            4: bs = 16'hFFFF;
            5: bs = 16'($urandom_range(1, 65535));
            default: bs = 16'($urandom_range(1, 1024));
        endcase
        r = $urandom_range(0, 9);
        if (r < 6)
            cnt = 9'($urandom_range(0, 24));
        else if (r < 8)
            cnt = 9'd256;
        else if (r == 8)
            cnt = 9'($urandom_range(257, 511));
        else
            cnt = 9'($urandom_range(25, 255));
        r = $urandom_range(0, 9);
        if (r < 4)
            heap = fbpa_pkg::BYTES_MAX;
        else if (r < 6)
            heap = '0;
        else
            heap = 24'($urandom_range(0, 24'hFF_FFFF));
        wait_drained();
        program_pool(bs, cnt, heap);
        send_request(fbpa_pkg::KIND_INIT, 16'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    // Random traffic: mostly allocs and frees of granted blocks, some noise
    task automatic run_phase(input int unsigned items, input bit pressure);
        int unsigned                 sent;
        int unsigned                 pick;
        int unsigned                 pos;
        bit                          reshaped;
        logic [fbpa_pkg::KIND_W-1:0] kind;
        logic [fbpa_pkg::SIZE_W-1:0] size;
        logic [fbpa_pkg::IDX_W-1:0]  idx;
        sent     = 0;
        reshaped = 1'b0;
        reshape_pool();
        if (pressure)
            rsp_hold = HOLD_OFF;
        while (sent < items)
        begin
            if (!reshaped && sent >= items / 2)
            begin
                reshaped = 1'b1;
                reshape_pool();
            end
            pick = $urandom_range(0, 99);
            size = 16'($urandom);
            idx  = 8'($urandom);
            if (pick < 48)
            begin
                kind = fbpa_pkg::KIND_ALLOC;
                case ($urandom_range(0, 9))
                    7, 8: size = 16'($urandom_range(0, 65535));
                    9:
                    begin
                        case ($urandom_range(0, 3))
                            0: size = 16'd0;
                            1: size = 16'hFFFF;
                            2: size = cfg_block_size;
                            default: size = 16'(cfg_block_size + 1);
                        endcase
                    end
                    default: size = 16'($urandom_range(0, cfg_block_size));
                endcase
            end
            else if (pick < 92)
            begin
                kind = fbpa_pkg::KIND_FREE;
                if (held_blocks.size() != 0 && $urandom_range(0, 9) < 8)
                begin
                    pos = $urandom_range(0, held_blocks.size() - 1);
                    idx = held_blocks[pos];
                    held_blocks.delete(pos);
                end
            end
            else if (pick < 97)
                kind = fbpa_pkg::KIND_INIT;
            else
                kind = KIND_NONE;
            send_request(kind, size, idx, 1'b0, '0);
            if (kind != KIND_NONE)
                sent++;
        end
    endtask

    // Response side: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (rsp_hold != 0)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Predict on every taken request, check every taken reply
    always @(posedge clk)
    begin : monitor
        pool_reply_t model_reply;
        pool_reply_t due;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                model_reply = predict_pool(req_ch.kind, req_ch.request_size,
                                           req_ch.block_index);
                requests_seen++;
                if (req_ch.kind == fbpa_pkg::KIND_INIT)
                begin
                    held_blocks.delete();
                    inits++;
                end
                if (req_ch.kind == fbpa_pkg::KIND_ALLOC && model_reply.status == fbpa_pkg::ST_OK)
                begin
                    held_blocks.push_back(model_reply.granted_index);
                    grants++;
                end
                if (model_reply.status == fbpa_pkg::ST_ALLOC_ERR)
                    refusals++;
                if (model_reply.status == fbpa_pkg::ST_FREE_DROP)
                    dropped_frees++;
                pool_replies_due.push_back(want_typed ? typed_reply : model_reply);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pool_replies_due.size() == 0)
                    note_error("reply with no request outstanding");
                else
                begin
                    due = pool_replies_due.pop_front();
                    replies_checked++;
                    check_field("status", due.status, rsp_ch.status);
                    check_field("granted_index", due.granted_index, rsp_ch.granted_index);
                    check_field("free_bytes", due.free_bytes, rsp_ch.free_bytes);
                    check_field("peak_used_bytes", due.peak_used_bytes,
                                rsp_ch.peak_used_bytes);
                    check_field("failed_requests", due.failed_requests,
                                rsp_ch.failed_requests);
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = fbpa_pkg::KIND_ALLOC;
        req_ch.request_size = '0;
        req_ch.block_index  = '0;
        rsp_ch.ready        = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        ring_head           = 0;
        ring_tail           = 0;
        free_total          = 0;
        peak_used           = '0;
        fail_count          = '0;
        cfg_block_size      = fbpa_pkg::BLOCK_SIZE_RST;
        cfg_block_count     = '0;
        cfg_heap_bytes      = '0;
        want_typed          = 1'b0;
        typed_reply         = '0;
        src_idle_pct        = 0;
        snk_idle_pct        = 0;
        rsp_hold            = 0;
        reply_errors        = 0;
        requests_seen       = 0;
        replies_checked     = 0;
        grants              = 0;
        refusals            = 0;
        dropped_frees       = 0;
        inits               = 0;
        settings            = 0;
        quiet_cycles        = 0;
        for (int i = 0; i < int'(POOL_DEPTH); i++)
            pool_ring[i] = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table, no idling
        foreach (DIRECTED_ROWS[i])
        begin
            case (DIRECTED_ROWS[i].op)
                ROW_CFG:
                begin
                    wait_drained();
                    program_pool(DIRECTED_ROWS[i].size, DIRECTED_ROWS[i].count,
                                 DIRECTED_ROWS[i].heap);
                end
                ROW_TYPED:
                    send_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].size,
                                 DIRECTED_ROWS[i].idx, 1'b1, DIRECTED_ROWS[i].want);
                default:
                    send_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].size,
                                 DIRECTED_ROWS[i].idx, 1'b0, '0);
            endcase
        end

        // Random traffic: slow receiver, then slow sender, then no idling after a long receiver hold-off
        src_idle_pct = 12;
        snk_idle_pct = 80;
        run_phase(PHASE_ITEMS, 1'b0);
        src_idle_pct = 80;
        snk_idle_pct = 12;
        run_phase(PHASE_ITEMS, 1'b0);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_phase(PHASE_ITEMS, 1'b1);

        wait_drained();
        repeat (END_PAUSE) @(posedge clk);
        if (pool_replies_due.size() != 0)
            note_error($sformatf("%0d replies never arrived", pool_replies_due.size()));

        $display("covered %0d requests over %0d pool settings, %0d replies checked",
                 requests_seen, settings, replies_checked);
        $display("grants %0d, refused allocs %0d, dropped frees %0d, inits %0d, errors %0d",
                 grants, refusals, dropped_frees, inits, reply_errors);
        if (reply_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
